[src/lsc_pkg.sv]
// shared types and constants for the load/store two-way write-back cache
`default_nettype none

package lsc_pkg;

	localparam int SETS_DEF = 8;
	localparam int MEM_WORDS_DEF = 128;
	localparam int SAVED_REGS_DEF = 8;
	localparam int QUEUE_DEPTH = 2;
	localparam int REG_IDX_W = 4;

	localparam logic [5:0] OP_LW = 6'd35;
	localparam logic [5:0] OP_SW = 6'd43;

	localparam logic [4:0] SAVED_MASK = 5'b11000;
	localparam logic [4:0] SAVED_BASE = 5'b10000;
	localparam logic [4:0] SAVED_SEL = 5'b00111;

	localparam logic [31:0] MEM_INIT_BIAS = 32'd5;

	typedef enum logic [2:0] {
		ST_OK = 3'd0,
		ST_BAD_OP = 3'd1,
		ST_BAD_RS = 3'd2,
		ST_BAD_RT = 3'd3,
		ST_RANGE = 3'd4
	} status_t;

	typedef struct packed {
		status_t status;
		logic is_load;
		logic [REG_IDX_W-1:0] rs;
		logic [REG_IDX_W-1:0] rt;
		logic [15:0] offset;
	} entry_t;

	typedef enum logic [2:0] {
		BK_INIT,
		BK_IDLE,
		BK_ADDR,
		BK_DIV,
		BK_LOOK,
		BK_EXEC,
		BK_FAIL
	} back_state_t;

endpackage

`default_nettype wire

[src/lsc_ram.sv]
// generic single-write, single-read ram with registered read data
`default_nettype none

module lsc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 2
) (
	input logic clk,
	input logic we,
	input logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic re,
	input logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

[src/lsc_front.sv]
// front end: takes instruction beats, decodes and classifies them
`default_nettype none

module lsc_front
	import lsc_pkg::*;
#(
	parameter int SAVED_REGS = SAVED_REGS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic init_busy,
	input logic in_valid,
	output logic in_stall,
	input logic [31:0] instruction_word,
	output logic push,
	output entry_t push_ent,
	input logic q_ready
);

	logic vld_s1;
	entry_t ent_s1;
	entry_t ent_c;
	logic accept;
	logic [5:0] op;
	logic [4:0] rs_field;
	logic [4:0] rt_field;
	logic [REG_IDX_W-1:0] rs_idx;
	logic [REG_IDX_W-1:0] rt_idx;

	function automatic logic [REG_IDX_W-1:0] saved_idx(input logic [4:0] field);
		logic [REG_IDX_W-1:0] k;
		k = REG_IDX_W'(field & SAVED_SEL);
		if ((field & SAVED_MASK) == SAVED_BASE && k < REG_IDX_W'(SAVED_REGS)) begin
			return REG_IDX_W'(k + 1'b1);
		end
		return '0;
	endfunction

	always_comb begin
		op = instruction_word[31:26];
		rs_field = instruction_word[25:21];
		rt_field = instruction_word[20:16];
		rs_idx = saved_idx(rs_field);
		rt_idx = saved_idx(rt_field);
		ent_c.is_load = (op == OP_LW);
		ent_c.rs = rs_idx;
		ent_c.rt = rt_idx;
		ent_c.offset = instruction_word[15:0];
		if (op != OP_LW && op != OP_SW) begin
			ent_c.status = ST_BAD_OP;
		end else if (rs_field != 5'd0 && rs_idx == '0) begin
			ent_c.status = ST_BAD_RS;
		end else if (rt_idx == '0) begin
			ent_c.status = ST_BAD_RT;
		end else begin
			ent_c.status = ST_OK;
		end
	end

	assign in_stall = init_busy | (vld_s1 & ~q_ready);
	assign accept = in_valid & ~in_stall;
	assign push = vld_s1;
	assign push_ent = ent_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= accept | (vld_s1 & ~q_ready);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ent_s1 <= ent_c;
		end
	end

endmodule

`default_nettype wire

[src/lsc_queue.sv]
// short fifo of decoded items between front and back
`default_nettype none

module lsc_queue
	import lsc_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic push,
	input entry_t push_ent,
	output logic ready,
	input logic pop,
	output logic head_vld,
	output entry_t head_ent
);

	localparam int PW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	entry_t slot_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] cnt_q;
	logic push_ok;
	logic pop_ok;

	assign ready = (cnt_q != CW'(QUEUE_DEPTH));
	assign head_vld = (cnt_q != '0);
	assign head_ent = slot_q[rd_ptr_q];
	assign push_ok = push & ready;
	assign pop_ok = pop & head_vld;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push_ok) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : PW'(wr_ptr_q + 1'b1);
			end
			if (pop_ok) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : PW'(rd_ptr_q + 1'b1);
			end
			cnt_q <= CW'(cnt_q + CW'(push_ok) - CW'(pop_ok));
		end
	end

	always_ff @(posedge clk) begin
		if (push_ok) begin
			slot_q[wr_ptr_q] <= push_ent;
		end
	end

endmodule

`default_nettype wire

[src/lsc_back.sv]
// back end: register file, cache ways, lru and main memory with the access sequencer
`default_nettype none

module lsc_back
	import lsc_pkg::*;
#(
	parameter int SETS = SETS_DEF,
	parameter int MEM_WORDS = MEM_WORDS_DEF,
	parameter int SAVED_REGS = SAVED_REGS_DEF
) (
	input logic clk,
	input logic arst_n,
	output logic init_busy,
	input logic head_vld,
	input entry_t head_ent,
	output logic pop,
	output logic out_valid,
	input logic out_stall,
	output logic [2:0] status,
	output logic hit,
	output logic is_load,
	output logic [3:0] dest_reg,
	output logic [31:0] load_value
);

	localparam int SET_W = (SETS > 1) ? $clog2(SETS) : 1;
	localparam int MW = $clog2(MEM_WORDS);
	localparam int RF_DEPTH = SAVED_REGS + 1;
	localparam int RF_W = $clog2(RF_DEPTH);
	localparam int TAGS = (MEM_WORDS + SETS - 1) / SETS;
	localparam int TAG_W = (TAGS > 1) ? $clog2(TAGS) : 1;
	localparam int WAY_W = TAG_W + 34;
	localparam int INIT_A = (MEM_WORDS >= SETS) ? MEM_WORDS : SETS;
	localparam int INIT_LEN = (INIT_A >= RF_DEPTH) ? INIT_A : RF_DEPTH;
	localparam int INIT_W = $clog2(INIT_LEN);
	localparam logic [32:0] RECIP = 33'((64'd1 << 32) / SETS);

	back_state_t state_q;
	back_state_t state_d;
	logic [INIT_W-1:0] init_cnt_q;
	entry_t ent_q;
	logic [MW-1:0] addr_q;
	logic range_err_q;
	logic [15:0] q_est_q;
	logic [SET_W-1:0] set_q;
	logic [TAG_W-1:0] tag_q;
	logic [31:0] store_q;

	logic out_vld_q;
	status_t status_q;
	logic hit_q;
	logic is_load_q;
	logic [3:0] dest_q;
	logic [31:0] value_q;

	logic rf_we;
	logic [RF_W-1:0] rf_waddr;
	logic [31:0] rf_wdata;
	logic rf_re;
	logic [RF_W-1:0] rf_raddr;
	logic [31:0] rf_rdata;

	logic mem_we;
	logic [MW-1:0] mem_waddr;
	logic [31:0] mem_wdata;
	logic mem_re;
	logic [MW-1:0] mem_raddr;
	logic [31:0] mem_rdata;

	logic w0_we;
	logic w1_we;
	logic lru_we;
	logic [SET_W-1:0] set_waddr;
	logic [WAY_W-1:0] way_wdata;
	logic lru_wdata;
	logic set_re;
	logic [SET_W-1:0] set_raddr;
	logic [WAY_W-1:0] w0_rdata;
	logic [WAY_W-1:0] w1_rdata;
	logic lru_rdata;

	logic [31:0] sum;
	logic [29:0] word;
	logic [48:0] q_prod;
	logic [31:0] qs;
	logic [31:0] rem;
	logic rem_hi;
	logic [SET_W-1:0] set_c;
	logic [TAG_W-1:0] tag_c;
	logic w0_vld;
	logic w0_dty;
	logic [TAG_W-1:0] w0_tag;
	logic [31:0] w0_dat;
	logic w1_vld;
	logic w1_dty;
	logic [TAG_W-1:0] w1_tag;
	logic [31:0] w1_dat;
	logic hit0;
	logic hit1;
	logic found;
	logic vic_vld;
	logic vic_dty;
	logic [TAG_W-1:0] vic_tag;
	logic [31:0] vic_dat;
	logic [31:0] wb;
	logic wb_ok;
	logic [31:0] ld_value;
	logic out_free;
	logic emit;

	lsc_ram #(.WIDTH(32), .DEPTH(RF_DEPTH)) u_rf (
		.clk(clk), .we(rf_we), .waddr(rf_waddr), .wdata(rf_wdata),
		.re(rf_re), .raddr(rf_raddr), .rdata(rf_rdata)
	);

	lsc_ram #(.WIDTH(32), .DEPTH(MEM_WORDS)) u_mem (
		.clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
		.re(mem_re), .raddr(mem_raddr), .rdata(mem_rdata)
	);

	lsc_ram #(.WIDTH(WAY_W), .DEPTH(SETS)) u_way0 (
		.clk(clk), .we(w0_we), .waddr(set_waddr), .wdata(way_wdata),
		.re(set_re), .raddr(set_raddr), .rdata(w0_rdata)
	);

	lsc_ram #(.WIDTH(WAY_W), .DEPTH(SETS)) u_way1 (
		.clk(clk), .we(w1_we), .waddr(set_waddr), .wdata(way_wdata),
		.re(set_re), .raddr(set_raddr), .rdata(w1_rdata)
	);

	lsc_ram #(.WIDTH(1), .DEPTH(SETS)) u_lru (
		.clk(clk), .we(lru_we), .waddr(set_waddr), .wdata(lru_wdata),
		.re(set_re), .raddr(set_raddr), .rdata(lru_rdata)
	);

	// datapath
	always_comb begin
		sum = rf_rdata + {16'd0, ent_q.offset};
		word = sum[31:2];
		q_prod = 49'(addr_q) * 49'(RECIP);
		qs = 32'(q_est_q) * 32'(SETS);
		rem = 32'(addr_q) - qs;
		rem_hi = (rem >= 32'(SETS));
		set_c = rem_hi ? SET_W'(rem - 32'(SETS)) : SET_W'(rem);
		tag_c = rem_hi ? TAG_W'(q_est_q + 16'd1) : TAG_W'(q_est_q);

		w0_vld = w0_rdata[WAY_W-1];
		w0_dty = w0_rdata[WAY_W-2];
		w0_tag = w0_rdata[32 +: TAG_W];
		w0_dat = w0_rdata[31:0];
		w1_vld = w1_rdata[WAY_W-1];
		w1_dty = w1_rdata[WAY_W-2];
		w1_tag = w1_rdata[32 +: TAG_W];
		w1_dat = w1_rdata[31:0];

		hit0 = w0_vld && (w0_tag == tag_q);
		hit1 = !hit0 && w1_vld && (w1_tag == tag_q);
		found = hit0 || hit1;

		vic_vld = lru_rdata ? w1_vld : w0_vld;
		vic_dty = lru_rdata ? w1_dty : w0_dty;
		vic_tag = lru_rdata ? w1_tag : w0_tag;
		vic_dat = lru_rdata ? w1_dat : w0_dat;
		wb = 32'(vic_tag) * 32'(SETS) + 32'(set_q);
		wb_ok = vic_vld && vic_dty && (wb < 32'(MEM_WORDS));

		ld_value = hit0 ? w0_dat : (hit1 ? w1_dat : mem_rdata);
		out_free = !out_vld_q || !out_stall;
		emit = (state_q == BK_EXEC || state_q == BK_FAIL) && out_free;
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_INIT: begin
				if (init_cnt_q == INIT_W'(INIT_LEN - 1)) begin
					state_d = BK_IDLE;
				end
			end
			BK_IDLE: begin
				if (head_vld) begin
					state_d = (head_ent.status == ST_OK) ? BK_ADDR : BK_FAIL;
				end
			end
			BK_ADDR: begin
				state_d = BK_DIV;
			end
			BK_DIV: begin
				state_d = range_err_q ? BK_FAIL : BK_LOOK;
			end
			BK_LOOK: begin
				state_d = BK_EXEC;
			end
			BK_EXEC, BK_FAIL: begin
				if (out_free) begin
					state_d = BK_IDLE;
				end
			end
			default: begin
				state_d = BK_INIT;
			end
		endcase
	end

	// memory controls
	always_comb begin
		pop = 1'b0;
		rf_we = 1'b0;
		rf_waddr = '0;
		rf_wdata = '0;
		rf_re = 1'b0;
		rf_raddr = '0;
		mem_we = 1'b0;
		mem_waddr = '0;
		mem_wdata = '0;
		mem_re = 1'b0;
		mem_raddr = '0;
		w0_we = 1'b0;
		w1_we = 1'b0;
		lru_we = 1'b0;
		set_waddr = '0;
		way_wdata = '0;
		lru_wdata = 1'b0;
		set_re = 1'b0;
		set_raddr = '0;
		case (state_q)
			BK_INIT: begin
				rf_we = (32'(init_cnt_q) < 32'(RF_DEPTH));
				rf_waddr = RF_W'(init_cnt_q);
				mem_we = (32'(init_cnt_q) < 32'(MEM_WORDS));
				mem_waddr = MW'(init_cnt_q);
				mem_wdata = 32'(init_cnt_q) + MEM_INIT_BIAS;
				w0_we = (32'(init_cnt_q) < 32'(SETS));
				w1_we = w0_we;
				lru_we = w0_we;
				set_waddr = SET_W'(init_cnt_q);
			end
			BK_IDLE: begin
				pop = head_vld;
				rf_re = head_vld;
				rf_raddr = RF_W'(head_ent.rs);
			end
			BK_ADDR: begin
				rf_re = 1'b1;
				rf_raddr = RF_W'(ent_q.rt);
			end
			BK_LOOK: begin
				set_re = 1'b1;
				set_raddr = set_c;
				mem_re = 1'b1;
				mem_raddr = addr_q;
			end
			BK_EXEC: begin
				if (out_free) begin
					set_waddr = set_q;
					lru_we = found || ent_q.is_load;
					lru_wdata = found ? hit0 : !lru_rdata;
					if (ent_q.is_load) begin
						rf_we = 1'b1;
						rf_waddr = RF_W'(ent_q.rt);
						rf_wdata = ld_value;
						if (!found) begin
							mem_we = wb_ok;
							mem_waddr = MW'(wb);
							mem_wdata = vic_dat;
							w0_we = !lru_rdata;
							w1_we = lru_rdata;
							way_wdata = {1'b1, 1'b0, tag_q, mem_rdata};
						end
					end else if (found) begin
						w0_we = hit0;
						w1_we = hit1;
						way_wdata = {1'b1, 1'b1, tag_q, store_q};
					end else begin
						mem_we = 1'b1;
						mem_waddr = addr_q;
						mem_wdata = store_q;
					end
				end
			end
			default: begin
				pop = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_INIT;
			init_cnt_q <= '0;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == BK_INIT) begin
				init_cnt_q <= INIT_W'(init_cnt_q + 1'b1);
			end
			if (emit) begin
				out_vld_q <= 1'b1;
			end else if (!out_stall) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			ent_q <= head_ent;
		end else if (state_q == BK_DIV && range_err_q) begin
			ent_q.status <= ST_RANGE;
		end
		if (state_q == BK_ADDR) begin
			addr_q <= MW'(word);
			range_err_q <= (word >= 30'(MEM_WORDS));
		end
		if (state_q == BK_DIV) begin
			q_est_q <= q_prod[47:32];
			store_q <= rf_rdata;
		end
		if (state_q == BK_LOOK) begin
			set_q <= set_c;
			tag_q <= tag_c;
		end
		if (emit) begin
			status_q <= (state_q == BK_EXEC) ? ST_OK : ent_q.status;
			hit_q <= (state_q == BK_EXEC) && found;
			is_load_q <= (state_q == BK_EXEC) && ent_q.is_load;
			dest_q <= (state_q == BK_EXEC) ? ent_q.rt : 4'd0;
			value_q <= (state_q == BK_EXEC && ent_q.is_load) ? ld_value : 32'd0;
		end
	end

	assign init_busy = (state_q == BK_INIT);
	assign out_valid = out_vld_q;
	assign status = status_q;
	assign hit = hit_q;
	assign is_load = is_load_q;
	assign dest_reg = dest_q;
	assign load_value = value_q;

	a_no_pop_in_init: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == BK_INIT |-> !pop)
		else $error("queue popped during clearing pass");

	a_no_dup_tags: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_EXEC && w0_vld && w1_vld) |-> (w0_tag != w1_tag))
		else $error("both ways of a set hold the same tag");

	a_fail_has_code: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == BK_FAIL |-> ent_q.status != ST_OK)
		else $error("error result without an error code");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q && out_stall |=> out_vld_q && $stable(value_q) && $stable(status_q))
		else $error("pending result overwritten");

	a_mem_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> 32'(mem_waddr) < 32'(MEM_WORDS))
		else $error("memory write beyond last word");

endmodule

`default_nettype wire

[src/load_store_two_way_writeback_cache.sv]
// top level of the load/store two-way write-back cache
// an accepted beat is held in the decode register, then waits in a two-entry queue
// the back end takes one lw/sw at a time: pop, address add, tag quotient, set read, update;
// an address out of range fails after the tag quotient and a bad opcode or register after the pop
// after reset the back end clears and preloads its memories with in_stall held high
`default_nettype none

module load_store_two_way_writeback_cache
	import lsc_pkg::*;
#(
	parameter int SETS = SETS_DEF,
	parameter int MEM_WORDS = MEM_WORDS_DEF,
	parameter int SAVED_REGS = SAVED_REGS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic [31:0] instruction_word,
	output logic out_valid,
	input logic out_stall,
	output logic [2:0] status,
	output logic hit,
	output logic is_load,
	output logic [3:0] dest_reg,
	output logic [31:0] load_value
);

	logic init_busy;
	logic push;
	entry_t push_ent;
	logic q_ready;
	logic pop;
	logic head_vld;
	entry_t head_ent;

	lsc_front #(.SAVED_REGS(SAVED_REGS)) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.init_busy(init_busy),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.instruction_word(instruction_word),
		.push(push),
		.push_ent(push_ent),
		.q_ready(q_ready)
	);

	lsc_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_ent(push_ent),
		.ready(q_ready),
		.pop(pop),
		.head_vld(head_vld),
		.head_ent(head_ent)
	);

	lsc_back #(
		.SETS(SETS),
		.MEM_WORDS(MEM_WORDS),
		.SAVED_REGS(SAVED_REGS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.init_busy(init_busy),
		.head_vld(head_vld),
		.head_ent(head_ent),
		.pop(pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.hit(hit),
		.is_load(is_load),
		.dest_reg(dest_reg),
		.load_value(load_value)
	);

endmodule

`default_nettype wire
